// ===== sv/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants for the bad-sector table block
// Table size, field widths, request and status codes, channel beats, FSM.
// ----------------------------------------------------------------------------
package bst_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 126;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W       = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TPC   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd2;

  localparam logic [7:0]  SPT_RESET   = 8'd32;
  localparam logic [7:0]  TPC_RESET   = 8'd16;
  localparam logic [31:0] TOTAL_RESET = 32'd0;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_ADD   = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_PRESENT = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;
  localparam logic [1:0] STAT_NOSPACE = 2'd3;

  // divider: 32-bit dividend, 8-bit divisor, one quotient bit per cycle
  localparam int DVD_W = 32;
  localparam int DVS_W = 8;
  localparam int DIV_STEP_W = $clog2(DVD_W + 1);

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] sector_number;
    logic [15:0] entry_cylinder;
    logic [15:0] entry_track_sector;
    logic [1:0]  clear_select;
  } bst_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] added_cylinder;
    logic [15:0] added_track_sector;
    logic [6:0]  current_count;
    logic [6:0]  new_count;
    logic        new_unsorted;
  } bst_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } bst_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } bst_div_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_DIV2,
    S_WALK,
    S_DONE
  } bst_state_t;

endpackage

// ===== sv/bst_if.sv =====
// ----------------------------------------------------------------------------
// bst_if: request and response channels
// Valid/ready handshake; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bst_req_if;
  import bst_pkg::*;

  logic     valid;
  logic     ready;
  bst_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bst_rsp_if;
  import bst_pkg::*;

  logic     valid;
  logic     ready;
  bst_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/bst_ram.sv =====
// ----------------------------------------------------------------------------
// bst_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 126
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/bst_div.sv =====
// ----------------------------------------------------------------------------
// bst_div: iterative restoring divider
// 32-bit by 8-bit unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bst_div (
  input  logic                  clk,
  input  logic                  rst,
  input  bst_pkg::bst_div_req_t dreq,
  output bst_pkg::bst_div_res_t dres
);
  import bst_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_STEP_W-1:0] steps;
  logic [DVD_W-1:0]      dvd;    // dividend shifts out, quotient shifts in
  logic [DVS_W-1:0]      dvs;
  logic [DVS_W-1:0]      rem;
  logic [DVS_W:0]        trial;
  logic                  ge;

  assign trial = {rem, dvd[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == DIV_STEP_W'(1));
      if (dreq.start) begin
        busy  <= 1'b1;
        steps <= DIV_STEP_W'(DVD_W);
      end else if (busy) begin
        steps <= steps - DIV_STEP_W'(1);
        if (steps == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dreq.start) begin
      dvd <= dreq.dividend;
      dvs <= dreq.divisor;
      rem <= '0;
    end else if (busy) begin
      // remainder stays below the divisor, so the shifted value fits 9 bits
      rem <= ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
    end
  end

  assign dres.done = done;
  assign dres.quot = dvd;
  assign dres.rem  = rem;

endmodule

// ===== sv/bad_sector_table_add.sv =====
// ----------------------------------------------------------------------------
// bad_sector_table_add: bad-sector table, add path
// Current table: user loads it sorted, unchecked; new table takes appended entries;
// an add splits a sector number into cylinder/track/sector and checks it.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          beat
//  -------  ---  -----------------  -----------------------------------------
//  req      in   valid/ready        request: clear, load entry or add sector
//  rsp      out  valid/ready        status, computed entry, counts, flag
//  cfg      in   cfg_wr_en (no wait) geometry and unit size registers
//
//  Clear, load and unused requests, and an add out of range, pass from
//  accept to the done state and then into the output register. An add in
//  range runs the shared divider twice (by sectors/track, then by
//  tracks/cylinder), then walks the current table at one entry per cycle
//  from its start, stopping at the count or at the first entry not below
//  the computed one, and goes on to the done state.
//  Reset is synchronous; the tables need no clearing pass: a fill count
//  bounds every read, so requests are taken from the first cycle on.
//  A new request is taken while a result waits in the output register; a
//  stalled rsp holds its beat, and the next result waits until it leaves.
//
module bad_sector_table_add (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [bst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bst_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  bst_req_if.sink                        req,
  bst_rsp_if.source                      rsp
);
  import bst_pkg::*;

  // control state
  bst_state_t       state;
  bst_state_t       state_next;
  logic [CNT_W-1:0] cur_cnt;
  logic [CNT_W-1:0] new_cnt;
  logic             unsorted;
  logic [CNT_W-1:0] idx;        // next current-table address to read
  logic             pend;       // read data of idx-1 arrives this cycle
  logic             rsp_valid;

  // configuration
  logic [7:0]  spt;
  logic [7:0]  tpc;
  logic [31:0] total;

  // payload
  logic [7:0]  sec_q;
  logic [7:0]  trk_q;
  logic [15:0] cyl_q;
  logic [1:0]  res_status;
  logic [15:0] res_cyl;
  logic [15:0] res_ts;
  bst_rsp_t    rsp_data;

  // datapath
  logic               accept;
  logic               out_free;
  logic               out_load;
  logic [33:0]        repl_start;
  logic               out_range;
  bst_div_req_t       div_req;
  bst_div_res_t       div_res;
  logic [ADDR_W-1:0]  cur_rd_addr;
  logic               cur_wr_en;
  logic [ENTRY_W-1:0] cur_rd_data;
  logic               new_wr_en;
  logic [15:0]        ts_q;
  logic               issue;
  logic               ent_lt;
  logic               ent_hit;
  logic               walk_finish;
  logic               walk_found;
  logic [CNT_W:0]     used_plus1;
  logic               no_space;
  logic               append_ok;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp_valid || rsp.ready;

  // replacement area start, signed: total - sectors/track - table size
  assign repl_start = {2'b00, total} - {26'd0, spt} - 34'(TABLE_ENTRIES);
  assign out_range  = (spt == 8'd0) || (tpc == 8'd0) ||
                      ($signed({2'b00, req.data.sector_number}) >= $signed(repl_start));

  // walk of the sorted current table; only rows below the count are read,
  // so the walk ends at the count or at the first entry not below the key
  assign ts_q    = {trk_q, sec_q};
  assign issue   = idx < cur_cnt;
  assign ent_lt  = (cur_rd_data[31:16] < cyl_q) ||
                   ((cur_rd_data[31:16] == cyl_q) && (cur_rd_data[15:0] < ts_q));
  assign ent_hit = (cur_rd_data[31:16] == cyl_q) && (cur_rd_data[15:0] == ts_q);
  assign walk_finish = (pend && !ent_lt) || !issue;
  assign walk_found  = pend && ent_hit;

  assign used_plus1 = {1'b0, cur_cnt} + {1'b0, new_cnt} + (CNT_W+1)'(1);
  assign no_space   = used_plus1 >= (CNT_W+1)'(TABLE_ENTRIES);
  assign append_ok  = !walk_found && !no_space && (new_cnt < CNT_W'(TABLE_ENTRIES));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.data.req_type == REQ_ADD && !out_range) begin
            state_next = S_DIV1;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DIV1: begin
        if (div_res.done) begin
          state_next = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_res.done) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_finish) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer; ready is high in idle, so valid alone accepts
  always_comb begin
    req.ready        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = req.data.sector_number;
    div_req.divisor  = spt;
    cur_wr_en        = 1'b0;
    new_wr_en        = 1'b0;
    out_load         = 1'b0;
    cur_rd_addr      = idx[ADDR_W-1:0];
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid && req.data.req_type == REQ_ADD && !out_range) begin
          div_req.start = 1'b1;
        end
        if (req.valid && req.data.req_type == REQ_LOAD &&
            cur_cnt < CNT_W'(TABLE_ENTRIES)) begin
          cur_wr_en = 1'b1;
        end
      end
      S_DIV1: begin
        // second pass: (sector / sectors per track) by tracks per cylinder
        div_req.dividend = div_res.quot;
        div_req.divisor  = tpc;
        div_req.start    = div_res.done;
      end
      S_DIV2: begin
      end
      S_WALK: begin
        new_wr_en = walk_finish && append_ok;
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_cnt   <= '0;
      new_cnt   <= '0;
      unsorted  <= 1'b0;
      idx       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
      spt       <= SPT_RESET;
      tpc       <= TPC_RESET;
      total     <= TOTAL_RESET;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SPT:   spt   <= cfg_wr_data[7:0];
          CFG_TPC:   tpc   <= cfg_wr_data[7:0];
          CFG_TOTAL: total <= cfg_wr_data[31:0];
          default: begin
          end
        endcase
      end

      if (accept && req.data.req_type == REQ_CLEAR) begin
        if (req.data.clear_select[0]) begin
          cur_cnt <= '0;
        end
        if (req.data.clear_select[1]) begin
          new_cnt <= '0;
        end
      end
      if (cur_wr_en) begin
        cur_cnt <= cur_cnt + CNT_W'(1);
      end
      if (new_wr_en) begin
        new_cnt  <= new_cnt + CNT_W'(1);
        unsorted <= 1'b1;
      end

      // walk pointer: one read issued per cycle
      if (state == S_WALK) begin
        pend <= issue && !walk_finish;
        if (issue) begin
          idx <= idx + CNT_W'(1);
        end
      end else begin
        pend <= 1'b0;
        idx  <= '0;
      end

      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= (req.data.req_type == REQ_ADD && out_range) ? STAT_RANGE : STAT_OK;
      res_cyl    <= '0;
      res_ts     <= '0;
    end
    if (state == S_DIV1 && div_res.done) begin
      sec_q <= div_res.rem;
    end
    if (state == S_DIV2 && div_res.done) begin
      trk_q <= div_res.rem;
      cyl_q <= div_res.quot[15:0];
    end
    if (state == S_WALK && walk_finish) begin
      res_cyl <= cyl_q;
      res_ts  <= ts_q;
      if (walk_found) begin
        res_status <= STAT_PRESENT;
      end else if (!append_ok) begin
        res_status <= STAT_NOSPACE;
      end else begin
        res_status <= STAT_OK;
      end
    end
    if (out_load) begin
      rsp_data.status             <= res_status;
      rsp_data.added_cylinder     <= res_cyl;
      rsp_data.added_track_sector <= res_ts;
      rsp_data.current_count      <= 7'(cur_cnt);
      rsp_data.new_count          <= 7'(new_cnt);
      rsp_data.new_unsorted       <= unsorted;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  bst_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (div_req),
    .dres (div_res)
  );

  // current table: written by loads, read by the walk
  bst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_cur_ram (
    .clk     (clk),
    .wr_en   (cur_wr_en),
    .wr_addr (cur_cnt[ADDR_W-1:0]),
    .wr_data ({req.data.entry_cylinder, req.data.entry_track_sector}),
    .rd_addr (cur_rd_addr),
    .rd_data (cur_rd_data)
  );

  // new table: appended entries; its read port is left unconnected here
  bst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_new_ram (
    .clk     (clk),
    .wr_en   (new_wr_en),
    .wr_addr (new_cnt[ADDR_W-1:0]),
    .wr_data ({cyl_q, ts_q}),
    .rd_addr ('0),
    .rd_data ()
  );

endmodule
